### hw/rtl/ilsb_pkg.sv
// Package for the indexed list shift buffer.
// Holds operation and status codes, fixed field widths and the cell command type.
// No dependencies.
package ilsb_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int IO_W     = 32;
    localparam int STAT_W   = 2;
    localparam int ECOUNT_W = 6;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic             insert;
        logic             erase;
        logic             push;
        logic             write;
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

endpackage

### hw/rtl/ilsb_cell.sv
// One storage cell of the indexed list shift buffer.
// Holds one entry and takes its left or right neighbor on insert or erase.
// Depends on ilsb_pkg.
module ilsb_cell #(
    parameter int IDX   = 0,
    parameter int DEPTH = 32,
    parameter int SW    = 32
) (
    input  logic                           i_clk,
    input  ilsb_pkg::t_cell_cmd            i_cmd,
    input  logic [$clog2(DEPTH+1)-1:0]     i_count,
    input  logic [SW-1:0]                  i_word,
    input  logic [SW-1:0]                  i_left,
    input  logic [SW-1:0]                  i_right,
    output logic [SW-1:0]                  o_word
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > ilsb_pkg::POS_W) ? CNT_W : ilsb_pkg::POS_W) + 1;

    logic [SW-1:0]    r_word;
    logic [SW-1:0]    n_word;
    logic [CMP_W-1:0] c_idx;
    logic [CMP_W-1:0] c_nxt;
    logic [CMP_W-1:0] c_pos;
    logic [CMP_W-1:0] c_cnt;

    assign c_idx = CMP_W'(IDX);
    assign c_nxt = CMP_W'(IDX + 1);
    assign c_pos = CMP_W'(i_cmd.pos);
    assign c_cnt = CMP_W'(i_count);

    always_comb begin
        n_word = r_word;
        if (i_cmd.insert && c_idx > c_pos && c_idx <= c_cnt) begin
            n_word = i_left;
        end else if (i_cmd.insert && c_idx == c_pos) begin
            n_word = i_word;
        end else if (i_cmd.erase && c_idx >= c_pos && c_nxt < c_cnt) begin
            n_word = i_right;
        end else if (i_cmd.push && c_idx == c_cnt) begin
            n_word = i_word;
        end else if (i_cmd.write && c_idx == c_pos) begin
            n_word = i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

### hw/rtl/indexed_list_shift_buffer.sv
// Top level of the indexed list shift buffer: a row of cells plus count and result register.
// Depends on ilsb_pkg and ilsb_cell.
//
//   channel | direction | handshake                  | payload
//   input   | in        | i_in_valid / o_in_ready    | i_opcode, i_position, i_word_in
//   output  | out       | o_out_valid / i_out_ready  | o_status, o_word_out,
//           |           |                            | o_entry_count, o_is_empty
//
// One word per cycle while the result is taken; the result is registered and appears in the cycle after acceptance.
// Every cell shifts, loads or holds in the same cycle, so insert and erase move the whole list at once.
// Synchronous active-low reset empties the list and clears the result valid flag.
// A stalled result holds; a new word is taken in the cycle the result leaves.
module indexed_list_shift_buffer #(
    parameter int DEPTH      = 32,
    parameter int WORD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ilsb_pkg::OP_W-1:0]      i_opcode,
    input  logic [ilsb_pkg::POS_W-1:0]     i_position,
    input  logic [ilsb_pkg::IO_W-1:0]      i_word_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ilsb_pkg::STAT_W-1:0]    o_status,
    output logic [ilsb_pkg::IO_W-1:0]      o_word_out,
    output logic [ilsb_pkg::ECOUNT_W-1:0]  o_entry_count,
    output logic                           o_is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > ilsb_pkg::POS_W) ? CNT_W : ilsb_pkg::POS_W) + 1;
    localparam int SW    = (WORD_WIDTH < ilsb_pkg::IO_W) ? WORD_WIDTH : ilsb_pkg::IO_W;
    localparam int RD_N  = (DEPTH < (1 << ilsb_pkg::POS_W)) ? DEPTH : (1 << ilsb_pkg::POS_W);

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_out_valid;
    logic [ilsb_pkg::STAT_W-1:0] r_status;
    logic [ilsb_pkg::IO_W-1:0]   r_word_out;
    logic [ilsb_pkg::ECOUNT_W-1:0] r_entry_count;
    logic                        r_is_empty;

    logic                        w_accept;
    logic [ilsb_pkg::STAT_W-1:0] w_status;
    logic [SW-1:0]               w_word;
    logic [SW-1:0]               w_rd;
    logic [CMP_W-1:0]            w_pos;
    logic [CMP_W-1:0]            w_cnt;
    logic                        w_range;
    logic                        w_full;
    logic                        w_none;
    ilsb_pkg::t_cell_cmd         w_cmd;
    logic [SW-1:0]               w_cell [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_word     = i_word_in[SW-1:0];
    assign w_pos      = CMP_W'(i_position);
    assign w_cnt      = CMP_W'(r_count);
    assign w_range    = w_pos >= w_cnt;
    assign w_full     = w_cnt == CMP_W'(DEPTH);
    assign w_none     = r_count == '0;

    always_comb begin
        w_status   = ilsb_pkg::ST_OK;
        n_count    = r_count;
        w_cmd      = '0;
        w_cmd.pos  = i_position;
        case (i_opcode)
            ilsb_pkg::OP_PUSH: begin
                if (w_full) begin
                    w_status = ilsb_pkg::ST_FULL;
                end else begin
                    w_cmd.push = w_accept;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            ilsb_pkg::OP_INSERT: begin
                if (w_range) begin
                    w_status = ilsb_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = ilsb_pkg::ST_FULL;
                end else begin
                    w_cmd.insert = w_accept;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            ilsb_pkg::OP_ERASE: begin
                if (w_range) begin
                    w_status = ilsb_pkg::ST_RANGE;
                end else begin
                    w_cmd.erase = w_accept;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            ilsb_pkg::OP_POP: begin
                if (w_none) begin
                    w_status = ilsb_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ilsb_pkg::OP_READ: begin
                if (w_range) begin
                    w_status = ilsb_pkg::ST_RANGE;
                end
            end
            ilsb_pkg::OP_WRITE: begin
                if (w_range) begin
                    w_status = ilsb_pkg::ST_RANGE;
                end else begin
                    w_cmd.write = w_accept;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_rd = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (ilsb_pkg::POS_W'(i) == i_position) begin
                w_rd = w_cell[i];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [SW-1:0] w_left;
        logic [SW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        ilsb_cell #(
            .IDX   (g),
            .DEPTH (DEPTH),
            .SW    (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_count (r_count),
            .i_word  (w_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= w_status;
            r_word_out    <= (i_opcode == ilsb_pkg::OP_READ && w_status == ilsb_pkg::ST_OK)
                             ? ilsb_pkg::IO_W'(w_rd) : '0;
            r_entry_count <= ilsb_pkg::ECOUNT_W'(n_count);
            r_is_empty    <= n_count == '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_word_out    = r_word_out;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;

endmodule

### hw/rtl/ilsb_checker.sv
// Port-level checks for the indexed list shift buffer, bound to the top level.
// Depends on ilsb_pkg and indexed_list_shift_buffer.
module ilsb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [ilsb_pkg::STAT_W-1:0]    o_status,
    input logic [ilsb_pkg::IO_W-1:0]      o_word_out,
    input logic [ilsb_pkg::ECOUNT_W-1:0]  o_entry_count,
    input logic                           o_is_empty
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_entry_count == '0)
        else $error("empty flag with nonzero count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ilsb_pkg::ST_OK |-> o_word_out == '0)
        else $error("failed operation returned a word");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ilsb_pkg::ST_EMPTY |-> o_is_empty)
        else $error("empty status on a nonempty list");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_word_out)
        && $stable(o_status) && $stable(o_entry_count))
        else $error("stalled result changed");

endmodule

bind indexed_list_shift_buffer ilsb_checker u_ilsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_word_out    (o_word_out),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);

### verif/tb_indexed_list_shift_buffer.sv
`timescale 1ns / 100ps
// Testbench for indexed_list_shift_buffer: directed and random list operations.
// Depends on ilsb_pkg and the block's RTL. A scoreboard class predicts each result.

import ilsb_pkg::*;

localparam int LIST_DEPTH = 32;
localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [IO_W-1:0]     word;
    logic [ECOUNT_W-1:0] count;
    logic                empty;
} t_list_result;

typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} t_op_mix;

class list_scoreboard;
    logic [IO_W-1:0] cells [LIST_DEPTH];
    int              fill;
    t_list_result    expected_q[$];
    int              errors;
    int              op_seen [8];
    int              status_seen [4];

    function new();
        fill   = 0;
        errors = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [IO_W-1:0] word);
        t_list_result res;
        int           idx;
        res.status = ST_OK;
        res.word   = '0;
        idx        = int'(pos);
        case (op)
            OP_PUSH: begin
                if (fill >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    cells[fill] = word;
                    fill++;
                end
            end
            OP_INSERT: begin
                if (idx >= fill) begin
                    res.status = ST_RANGE;
                end else if (fill >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = fill; i > idx; i--) cells[i] = cells[i-1];
                    cells[idx] = word;
                    fill++;
                end
            end
            OP_ERASE: begin
                if (idx >= fill) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = idx; i + 1 < fill; i++) cells[i] = cells[i+1];
                    fill--;
                end
            end
            OP_POP: begin
                if (fill == 0) res.status = ST_EMPTY;
                else fill--;
            end
            OP_READ: begin
                if (idx >= fill) res.status = ST_RANGE;
                else res.word = cells[idx];
            end
            OP_WRITE: begin
                if (idx >= fill) res.status = ST_RANGE;
                else cells[idx] = word;
            end
            default: begin
            end
        endcase
        res.count = fill[ECOUNT_W-1:0];
        res.empty = (fill == 0);
        op_seen[op]++;
        status_seen[res.status]++;
        expected_q.push_back(res);
    endfunction

    function void check_word(logic [STAT_W-1:0] status, logic [IO_W-1:0] word,
                             logic [ECOUNT_W-1:0] count, logic empty);
        t_list_result exp_res;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual status %0d count %0d",
                     $time, status, count);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (status !== exp_res.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_res.status, status);
            errors++;
        end
        if (word !== exp_res.word) begin
            $display("%0t: word_out mismatch, expected %h, actual %h",
                     $time, exp_res.word, word);
            errors++;
        end
        if (count !== exp_res.count) begin
            $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                     $time, exp_res.count, count);
            errors++;
        end
        if (empty !== exp_res.empty) begin
            $display("%0t: is_empty mismatch, expected %0b, actual %0b",
                     $time, exp_res.empty, empty);
            errors++;
        end
    endfunction
endclass

module tb_indexed_list_shift_buffer;

    localparam int STALL_LIMIT = 500;
    localparam int RANDOM_ITEMS = 1950;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_opcode;
    logic [POS_W-1:0]    i_position;
    logic [IO_W-1:0]     i_word_in;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STAT_W-1:0]   o_status;
    logic [IO_W-1:0]     o_word_out;
    logic [ECOUNT_W-1:0] o_entry_count;
    logic                o_is_empty;

    list_scoreboard sb = new();
    int             idle_mode;
    int             quiet_cycles;

    indexed_list_shift_buffer #(
        .DEPTH      (LIST_DEPTH),
        .WORD_WIDTH (IO_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_position    (i_position),
        .i_word_in     (i_word_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_word_out    (o_word_out),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        case (idle_mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [IO_W-1:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_position = pos;
        i_word_in  = word;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(op, pos, word);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(t_op_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 40) return OP_PUSH;
                if (r < 65) return OP_INSERT;
                if (r < 75) return OP_WRITE;
                if (r < 85) return OP_READ;
                if (r < 92) return OP_ERASE;
                return OP_POP;
            end
            MIX_DRAIN: begin
                if (r < 35) return OP_ERASE;
                if (r < 65) return OP_POP;
                if (r < 75) return OP_READ;
                if (r < 85) return OP_WRITE;
                if (r < 93) return OP_PUSH;
                return OP_INSERT;
            end
            MIX_BALANCED: return OP_W'($urandom_range(0, 5));
            default: return OP_W'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(t_op_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == MIX_NOISE || sb.fill == 0 || r < 10) return POS_W'($urandom_range(0, 31));
        if (r < 18 && sb.fill < LIST_DEPTH) return POS_W'(sb.fill);
        return POS_W'($urandom_range(0, sb.fill - 1));
    endfunction

    function automatic logic [IO_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    // result side: a random stall per word, possibly none, then take it
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_word(o_status, o_word_out, o_entry_count, o_is_empty);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_op_mix mix;
        int      sent;
        int      phase;
        int      len;
        logic [OP_W-1:0] op;

        idle_mode    = 2;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_PUSH;
        i_position   = '0;
        i_word_in    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty list refusals and ignored codes, then directed pushes, inserts, reads, writes, erases and pops
        send_word(OP_POP,    5'd0,  32'h0000_0000);
        send_word(OP_READ,   5'd0,  32'h0000_0000);
        send_word(OP_INSERT, 5'd0,  32'h1234_5678);
        send_word(OP_ERASE,  5'd0,  32'h0000_0000);
        send_word(OP_WRITE,  5'd0,  32'hFFFF_FFFF);
        send_word(OP_SPARE6, 5'd31, 32'hFFFF_FFFF);
        send_word(OP_SPARE7, 5'd31, 32'h0000_0000);
        send_word(OP_PUSH,   5'd31, 32'h0000_0000);
        send_word(OP_PUSH,   5'd0,  32'hFFFF_FFFF);
        send_word(OP_PUSH,   5'd0,  32'h5A5A_5A5A);
        send_word(OP_INSERT, 5'd0,  32'hA5A5_A5A5);
        send_word(OP_INSERT, 5'd4,  32'h0000_0001);
        send_word(OP_INSERT, 5'd3,  32'h8000_0000);
        send_word(OP_READ,   5'd0,  32'h0000_0000);
        send_word(OP_READ,   5'd4,  32'h0000_0000);
        send_word(OP_WRITE,  5'd4,  32'h7FFF_FFFF);
        send_word(OP_READ,   5'd31, 32'h0000_0000);
        send_word(OP_ERASE,  5'd0,  32'h0000_0000);
        send_word(OP_ERASE,  5'd3,  32'h0000_0000);
        send_word(OP_READ,   5'd3,  32'h0000_0000);
        send_word(OP_POP,    5'd0,  32'h0000_0000);
        send_word(OP_POP,    5'd0,  32'h0000_0000);
        send_word(OP_POP,    5'd0,  32'h0000_0000);
        send_word(OP_POP,    5'd0,  32'h0000_0000);
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            mix       = (phase == 0) ? MIX_FILL : t_op_mix'($urandom_range(0, 3));
            idle_mode = (phase == 0) ? 1 : $urandom_range(0, 2);
            len       = $urandom_range(40, 140);
            for (int n = 0; n < len; n++) begin
                op = pick_op(mix);
                send_word(op, pick_pos(mix), pick_word());
                if (op <= OP_WRITE) sent++;
            end
            // after the first phase, and at random after later ones, hold until every result has come back
            if (phase == 0 || $urandom_range(0, 3) == 0) wait_drained();
            phase++;
        end

        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("Ran %0d push, %0d insert, %0d erase, %0d pop, %0d read, %0d write, %0d ignored",
                 sb.op_seen[OP_PUSH], sb.op_seen[OP_INSERT], sb.op_seen[OP_ERASE],
                 sb.op_seen[OP_POP], sb.op_seen[OP_READ], sb.op_seen[OP_WRITE],
                 sb.op_seen[OP_SPARE6] + sb.op_seen[OP_SPARE7]);
        $display("Statuses: %0d ok, %0d out of range, %0d full, %0d empty over %0d phases",
                 sb.status_seen[ST_OK], sb.status_seen[ST_RANGE], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], phase);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
